/* sv/nwbc_pkg.sv */
`default_nettype none

package nwbc_pkg;

    localparam int MEMORY_BYTES_DEFAULT = 2048;
    localparam int ADDR_W = 11;
    localparam int DATA_W = 8;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    // clock byte offsets above the plain store
    localparam logic [2:0] CLK_CTRL  = 3'd0;
    localparam logic [2:0] CLK_SEC   = 3'd1;
    localparam logic [2:0] CLK_MIN   = 3'd2;
    localparam logic [2:0] CLK_HOUR  = 3'd3;
    localparam logic [2:0] CLK_WDAY  = 3'd4;
    localparam logic [2:0] CLK_DATE  = 3'd5;
    localparam logic [2:0] CLK_MONTH = 3'd6;
    localparam logic [2:0] CLK_YEAR  = 3'd7;

    // control bits 7 and 6 stop the clock
    localparam logic [DATA_W-1:0] TICK_HOLD_MASK = 8'hc0;

    typedef struct packed {
        logic [1:0]        op;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
        logic              burst_last;
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              last;
    } result_t;

    typedef struct packed {
        logic wr;
        logic rd;
    } store_ctl_t;

    typedef struct packed {
        logic wr;
        logic tick;
    } rtc_ctl_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              wrap;
    } step_t;

    // high nibble times ten plus low nibble, at most 165
    function automatic logic [7:0] bcd_value(input logic [7:0] b);
        return {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0} + {4'b0000, b[3:0]};
    endfunction

    // binary to bcd for values up to 99, tens by reciprocal multiply
    function automatic logic [7:0] to_bcd(input logic [7:0] v);
        logic [15:0] prod;
        logic [3:0]  tens;
        logic [7:0]  units;
        prod  = 16'(v) * 16'd205;
        tens  = prod[14:11];
        units = v - 8'({4'b0000, tens}) * 8'd10;
        return {tens, units[3:0]};
    endfunction

    function automatic step_t step_field(input logic [7:0] field, input logic [7:0] top,
                                         input logic [7:0] bottom);
        step_t      s;
        logic [7:0] v;
        v = bcd_value(field);
        if (v >= top) begin
            s.value = to_bcd(bottom);
            s.wrap  = 1'b1;
        end
        else if (v < bottom) begin
            s.value = to_bcd(bottom);
            s.wrap  = 1'b0;
        end
        else begin
            s.value = to_bcd(v + 8'd1);
            s.wrap  = 1'b0;
        end
        return s;
    endfunction

    function automatic logic [7:0] month_days(input logic [7:0] month, input logic [7:0] year);
        logic [7:0] m;
        logic [7:0] y;
        logic [7:0] days;
        m = bcd_value(month);
        y = bcd_value(year);
        case (m) inside
            8'd4, 8'd6, 8'd9, 8'd11: days = 8'd30;
            8'd2:                    days = (y[1:0] == 2'b00) ? 8'd29 : 8'd28;
            default:                 days = 8'd31;
        endcase
        return days;
    endfunction

endpackage

`default_nettype wire

/* sv/nvram_with_bcd_clock.sv */
`default_nettype none

// byte-wide nvram with a bcd real-time clock in its top eight bytes: control,
// seconds, minutes, hour, weekday, date, month, year. issue an item by raising
// start while busy is low; op selects read, write or a one-second tick. every
// accepted item is taken without stalling, so a new item can be issued on
// each clock while busy is low. a read shows its byte on result in the
// cycle after acceptance, with valid high for exactly that cycle; the
// receiver cannot stall, so capture it then. writes and ticks give no result.
// after reset busy stays high while the store is swept to zero; the clock
// bytes reset to zero at once. setting control bit 7 or 6 holds the clock.
module nvram_with_bcd_clock
    import nwbc_pkg::*;
#(
    parameter int MEMORY_BYTES = MEMORY_BYTES_DEFAULT
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  item_t   request,
    output logic    valid,
    output result_t result
);

    localparam int STORE_BYTES = MEMORY_BYTES - 8;
    localparam int SW          = $clog2(STORE_BYTES);

    logic              accept;
    logic              is_read;
    logic              is_write;
    logic              is_tick;
    logic              store_hit;
    logic [SW-1:0]     store_idx;
    logic [2:0]        clock_idx;
    store_ctl_t        store_ctl;
    rtc_ctl_t          rtc_ctl;
    logic [DATA_W-1:0] store_rdata;
    logic [DATA_W-1:0] rtc_rdata;
    logic              clearing;

    // result registers
    logic              valid_reg;
    logic              last_reg;
    logic              from_clock_reg;
    logic [DATA_W-1:0] clock_byte_reg;

    assign accept   = start && !busy;
    assign is_read  = accept && (request.op == OP_READ);
    assign is_write = accept && (request.op == OP_WRITE);
    assign is_tick  = accept && (request.op == OP_TICK);

    // fold the address into the store or the clock bytes
    nwbc_addr_dec #(
        .MEMORY_BYTES (MEMORY_BYTES),
        .STORE_BYTES  (STORE_BYTES),
        .SW           (SW)
    ) u_addr_dec (
        .address   (request.address),
        .store_hit (store_hit),
        .store_idx (store_idx),
        .clock_idx (clock_idx)
    );

    assign store_ctl.wr = is_write && store_hit;
    assign store_ctl.rd = is_read && store_hit;
    assign rtc_ctl.wr   = is_write && !store_hit;
    assign rtc_ctl.tick = is_tick;

    // byte store with a registered read port
    nwbc_store #(
        .DEPTH (STORE_BYTES),
        .IW    (SW)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (store_ctl),
        .idx      (store_idx),
        .wdata    (request.write_data),
        .rdata    (store_rdata),
        .clearing (clearing)
    );

    // clock bytes and tick carry chain
    nwbc_rtc u_rtc (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (rtc_ctl),
        .idx   (clock_idx),
        .wdata (request.write_data),
        .rdata (rtc_rdata)
    );

    assign busy = clearing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= is_read;
        end
    end

    // clock byte is sampled before any same-edge update
    always_ff @(posedge clk)
    begin
        if (is_read)
        begin
            last_reg       <= request.burst_last;
            from_clock_reg <= !store_hit;
            clock_byte_reg <= rtc_rdata;
        end
    end

    assign valid            = valid_reg;
    assign result.read_data = from_clock_reg ? clock_byte_reg : store_rdata;
    assign result.last      = last_reg;

`ifndef SYNTH
    // every accepted read gives exactly one strobe on the next cycle
    a_read_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (request.op == OP_READ)) |=> valid)
        else $error("read item gave no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> $past(start && !busy && (request.op == OP_READ)))
        else $error("result without a read item");

    // the clearing sweep runs once after reset only
    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !busy)
        else $error("busy came back after the clearing sweep");
`endif

endmodule

`default_nettype wire

/* sv/nwbc_addr_dec.sv */
`default_nettype none

module nwbc_addr_dec
    import nwbc_pkg::*;
#(
    parameter int MEMORY_BYTES = MEMORY_BYTES_DEFAULT,
    parameter int STORE_BYTES  = MEMORY_BYTES - 8,
    parameter int SW           = $clog2(STORE_BYTES)
)
(
    input  logic [ADDR_W-1:0] address,
    output logic              store_hit,
    output logic [SW-1:0]     store_idx,
    output logic [2:0]        clock_idx
);

    localparam int AW    = $clog2(MEMORY_BYTES);
    localparam int STEPS = $clog2((2 ** ADDR_W + MEMORY_BYTES - 1) / MEMORY_BYTES);

    logic [ADDR_W:0] rem;
    logic [AW-1:0]   offset;

    // restoring reduction, one compare and subtract per quotient bit
    always_comb
    begin
        rem = {1'b0, address};
        for (int k = STEPS - 1; k >= 0; k--)
        begin
            if (rem >= (ADDR_W + 1)'(MEMORY_BYTES << k))
            begin
                rem = rem - (ADDR_W + 1)'(MEMORY_BYTES << k);
            end
        end
    end

    assign offset    = AW'(rem);
    assign store_hit = offset < AW'(STORE_BYTES);
    assign store_idx = SW'(offset);
    assign clock_idx = 3'(offset - AW'(STORE_BYTES));

endmodule

`default_nettype wire

/* sv/nwbc_store.sv */
`default_nettype none

module nwbc_store
    import nwbc_pkg::*;
#(
    parameter int DEPTH = MEMORY_BYTES_DEFAULT - 8,
    parameter int IW    = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  store_ctl_t        ctl,
    input  logic [IW-1:0]     idx,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata,
    output logic              clearing
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;
    logic [IW-1:0]     clr_reg;
    logic [IW-1:0]     clr_next;
    logic              clearing_reg;
    logic              clearing_next;
    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;

    // zero sweep after reset
    always_comb
    begin
        clr_next      = clr_reg;
        clearing_next = clearing_reg;
        if (clearing_reg)
        begin
            clr_next = clr_reg + IW'(1);
            if (clr_reg == IW'(DEPTH - 1))
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= '0;
            clearing_reg <= 1'b1;
        end
        else
        begin
            clr_reg      <= clr_next;
            clearing_reg <= clearing_next;
        end
    end

    assign mem_we    = clearing_reg || ctl.wr;
    assign mem_waddr = clearing_reg ? clr_reg : idx;
    assign mem_wdata = clearing_reg ? '0 : wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (ctl.rd)
        begin
            rdata_reg <= mem[idx];
        end
    end

    assign rdata    = rdata_reg;
    assign clearing = clearing_reg;

endmodule

`default_nettype wire

/* sv/nwbc_rtc.sv */
`default_nettype none

module nwbc_rtc
    import nwbc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  rtc_ctl_t          ctl,
    input  logic [2:0]        idx,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] regs_reg  [8];
    logic [DATA_W-1:0] regs_next [8];
    step_t sec_s, min_s, hour_s, wday_s, date_s, month_s, year_s;
    logic  run;
    logic  c_min, c_hour, c_day, c_month, c_year;

    assign sec_s   = step_field(regs_reg[CLK_SEC], 8'd59, 8'd0);
    assign min_s   = step_field(regs_reg[CLK_MIN], 8'd59, 8'd0);
    assign hour_s  = step_field(regs_reg[CLK_HOUR], 8'd23, 8'd0);
    assign wday_s  = step_field(regs_reg[CLK_WDAY], 8'd7, 8'd1);
    assign date_s  = step_field(regs_reg[CLK_DATE],
                                month_days(regs_reg[CLK_MONTH], regs_reg[CLK_YEAR]), 8'd1);
    assign month_s = step_field(regs_reg[CLK_MONTH], 8'd12, 8'd1);
    assign year_s  = step_field(regs_reg[CLK_YEAR], 8'd99, 8'd0);

    assign run     = ctl.tick && ((regs_reg[CLK_CTRL] & TICK_HOLD_MASK) == 8'h00);
    assign c_min   = sec_s.wrap;
    assign c_hour  = c_min && min_s.wrap;
    assign c_day   = c_hour && hour_s.wrap;
    assign c_month = c_day && date_s.wrap;
    assign c_year  = c_month && month_s.wrap;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            regs_next[i] = regs_reg[i];
        end
        if (ctl.wr)
        begin
            regs_next[idx] = wdata;
        end
        else if (run)
        begin
            regs_next[CLK_SEC] = sec_s.value;
            if (c_min)
            begin
                regs_next[CLK_MIN] = min_s.value;
            end
            if (c_hour)
            begin
                regs_next[CLK_HOUR] = hour_s.value;
            end
            if (c_day)
            begin
                regs_next[CLK_WDAY] = wday_s.value;
                regs_next[CLK_DATE] = date_s.value;
            end
            if (c_month)
            begin
                regs_next[CLK_MONTH] = month_s.value;
            end
            if (c_year)
            begin
                regs_next[CLK_YEAR] = year_s.value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                regs_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < 8; i++)
            begin
                regs_reg[i] <= regs_next[i];
            end
        end
    end

    assign rdata = regs_reg[idx];

`ifndef SYNTH
    // a tick with the hold bits set leaves the seconds alone
    a_hold_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.tick && !ctl.wr && ((regs_reg[CLK_CTRL] & TICK_HOLD_MASK) != 8'h00))
        |=> $stable(regs_reg[CLK_SEC]))
        else $error("seconds moved while clock held");

    // a running tick always changes the seconds byte
    a_tick_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (run && !ctl.wr) |=> (regs_reg[CLK_SEC] != $past(regs_reg[CLK_SEC])))
        else $error("tick did not advance seconds");
`endif

endmodule

`default_nettype wire
